// ===== hdl/csc_pkg.sv =====
// Shared types, Q16 coefficients and helpers for the color space converter.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package csc_pkg;

  typedef enum logic [2:0] {
    MODE_RGB2GRAY  = 3'd0,
    MODE_GRAY2RGB  = 3'd1,
    MODE_RGB2HSV   = 3'd2,
    MODE_RGB2HLS   = 3'd3,
    MODE_HSV2RGB   = 3'd4,
    MODE_HLS2RGB   = 3'd5,
    MODE_RGB2YCRCB = 3'd6,
    MODE_YCRCB2RGB = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    SEC_R_Y,
    SEC_Y_G,
    SEC_G_C,
    SEC_C_B,
    SEC_B_M,
    SEC_M_R,
    SEC_NONE
  } sector_t;

  localparam int DIV_QW = 24;
  localparam int DIV_NW = 29;
  localparam int DIV_DW = 8;

  localparam logic [15:0] K_R  = 16'd19595;
  localparam logic [15:0] K_G  = 16'd38470;
  localparam logic [15:0] K_B  = 16'd7471;
  localparam logic signed [16:0] KS_CR = 17'sd46727;
  localparam logic signed [16:0] KS_CB = 17'sd36962;
  localparam logic signed [31:0] KS_RCR = 32'sd91947;
  localparam logic signed [31:0] KS_GCR = 32'sd46793;
  localparam logic signed [31:0] KS_GCB = 32'sd22544;
  localparam logic signed [31:0] KS_BCB = 32'sd116195;
  localparam logic signed [39:0] C_OFFSET_Q16 = 40'sd8388608;

  localparam logic [7:0] HUE_RED  = 8'd0;
  localparam logic [7:0] HUE_GRN  = 8'd60;
  localparam logic [7:0] HUE_BLU  = 8'd120;
  localparam logic [7:0] HUE_WRAP = 8'd180;

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_QW-1:0] acc;
    logic [DIV_DW-1:0] den;
  } lane_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  alpha;
    logic [7:0]  o0;
    logic [7:0]  o1;
    logic [7:0]  o2;
    logic [7:0]  hbase;
    logic        hneg;
    logic        zero;
    logic [7:0]  mx;
    logic [7:0]  lum;
    logic [23:0] cq;
    logic [23:0] mq;
    sector_t     sec;
  } side_t;

  typedef struct packed {
    lane_t main;
    lane_t hue;
    side_t side;
  } csc_work_t;

  // floor(q / 65536) clamped to 0..255
  function automatic logic [7:0] sat_q16(input logic signed [39:0] q);
    logic [7:0] res;
    if (q < 0) begin
      res = 8'd0;
    end else if (q[39:24] != 16'd0) begin
      res = 8'd255;
    end else begin
      res = q[23:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/csc_ifs.sv =====
// Pixel request channels of the color space converter: input and result.
// Each carries valid, ready and the channel fields; no dependencies.
`default_nettype none

interface csc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_first;
  logic [7:0] in_second;
  logic [7:0] in_third;
  logic [7:0] in_alpha;
  modport source(output valid, in_first, in_second, in_third, in_alpha, input ready);
  modport sink(input valid, in_first, in_second, in_third, in_alpha, output ready);
endinterface

interface csc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;
  logic [7:0] out_alpha;
  modport source(output valid, out_first, out_second, out_third, out_alpha, input ready);
  modport sink(input valid, out_first, out_second, out_third, out_alpha, output ready);
endinterface

`default_nettype wire

// ===== hdl/csc_front.sv =====
// Front end: four pipeline stages of max/min, products, divide by 255 and
// divider setup. Depends on csc_pkg and csc_in_if.
`default_nettype none

module csc_front import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mode_t     cfg_mode,
  csc_in_if.sink    up,
  output logic      dn_valid,
  input  logic      dn_ready,
  output csc_work_t dn_data
);

  logic en1, en2, en3, en4;

  // stage 1
  logic [7:0] a, b, c;
  logic red_max, grn_max;
  logic [7:0] mx, mn, hn, hbase, fm;
  logic hneg;
  sector_t sec;
  logic [4:0] k;
  logic [8:0] t2;
  logic [7:0] span;
  logic [15:0] prod;
  logic [23:0] yq;
  logic signed [31:0] ybase, p_rcr, p_gcr, p_gcb, p_bcb;
  logic signed [8:0] dcr, dcb;

  logic s1_v_r;
  mode_t s1_mode_r;
  logic [7:0] s1_a_r, s1_b_r, s1_c_r, s1_alpha_r, s1_mx_r, s1_mn_r, s1_hn_r, s1_hbase_r;
  logic s1_hneg_r;
  sector_t s1_sec_r;
  logic [4:0] s1_k_r;
  logic [15:0] s1_p_r;
  logic [23:0] s1_yq_r;
  logic signed [31:0] s1_y0_r, s1_y1_r, s1_y2_r;

  assign a = up.in_first;
  assign b = up.in_second;
  assign c = up.in_third;

  always_comb begin
    red_max = (a >= b) && (a >= c);
    grn_max = !red_max && (b >= c);
    mx = red_max ? a : (grn_max ? b : c);
    mn = a;
    if (b < mn) begin
      mn = b;
    end
    if (c < mn) begin
      mn = c;
    end
    priority if (red_max) begin
      hbase = (b >= c) ? HUE_RED : HUE_WRAP;
      hneg  = (b < c);
      hn    = (b >= c) ? b - c : c - b;
    end else if (grn_max) begin
      hbase = HUE_GRN;
      hneg  = (c < a);
      hn    = (c >= a) ? c - a : a - c;
    end else begin
      hbase = HUE_BLU;
      hneg  = (a < b);
      hn    = (a >= b) ? a - b : b - a;
    end
    priority if (a < 8'd30) begin
      sec = SEC_R_Y;
    end else if (a < 8'd60) begin
      sec = SEC_Y_G;
    end else if (a < 8'd90) begin
      sec = SEC_G_C;
    end else if (a < 8'd120) begin
      sec = SEC_C_B;
    end else if (a < 8'd150) begin
      sec = SEC_B_M;
    end else if (a < 8'd180) begin
      sec = SEC_M_R;
    end else begin
      sec = SEC_NONE;
    end
    unique case (sec)
      SEC_R_Y, SEC_Y_G: fm = a;
      SEC_G_C, SEC_C_B: fm = a - 8'd60;
      SEC_B_M, SEC_M_R: fm = a - 8'd120;
      default:          fm = 8'd0;
    endcase
    k = (fm >= 8'd30) ? 5'(8'd60 - fm) : fm[4:0];
    t2 = {b, 1'b0};
    span = (t2 >= 9'd255) ? 8'(9'd510 - t2) : t2[7:0];
    prod = (cfg_mode == MODE_HSV2RGB) ? 16'(b) * 16'(c) : 16'(span) * 16'(c);
    yq = 24'(K_R) * 24'(a) + 24'(K_G) * 24'(b) + 24'(K_B) * 24'(c);
    ybase = $signed({8'b0, a, 16'b0});
    dcr = $signed({1'b0, b}) - 9'sd128;
    dcb = $signed({1'b0, c}) - 9'sd128;
    p_rcr = 32'(dcr) * KS_RCR;
    p_gcr = 32'(dcr) * KS_GCR;
    p_gcb = 32'(dcb) * KS_GCB;
    p_bcb = 32'(dcb) * KS_BCB;
  end

  // stage 2
  logic [16:0] psum;
  logic [8:0] est;
  logic [16:0] m255;
  logic signed [17:0] rem;
  logic [7:0] qa, qb, dd, den_sat, lum, d0, d1, d2;
  logic [8:0] mmsum;
  logic signed [25:0] dr, db;
  logic signed [42:0] pcr, pcb;

  logic s2_v_r;
  mode_t s2_mode_r;
  logic [7:0] s2_b_r, s2_c_r, s2_alpha_r, s2_mx_r, s2_hn_r, s2_hbase_r;
  logic s2_hneg_r;
  sector_t s2_sec_r;
  logic [4:0] s2_k_r;
  logic [7:0] s2_qa_r, s2_qb_r, s2_d_r, s2_den_r, s2_lum_r, s2_o0_r, s2_o1_r, s2_o2_r;
  logic signed [42:0] s2_pcr_r, s2_pcb_r;

  always_comb begin
    psum = 17'(s1_p_r) + 17'(s1_p_r[15:8]) + 17'd1;
    est  = psum[16:8];
    m255 = 17'({est, 8'b0}) - 17'(est);
    rem  = $signed({2'b0, s1_p_r}) - $signed({1'b0, m255});
    priority if (rem >= 18'sd255) begin
      qa = 8'(est + 9'd1);
      qb = 8'(rem - 18'sd255);
    end else if (rem < 18'sd0) begin
      qa = 8'(est - 9'd1);
      qb = 8'(rem + 18'sd255);
    end else begin
      qa = est[7:0];
      qb = rem[7:0];
    end
    dd = s1_mx_r - s1_mn_r;
    mmsum = {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    lum = mmsum[8:1];
    if (s1_mode_r == MODE_RGB2HSV) begin
      den_sat = s1_mx_r;
    end else begin
      den_sat = (mmsum < 9'd255) ? mmsum[7:0] : 8'(9'd510 - mmsum);
    end
    unique case (s1_mode_r)
      MODE_RGB2GRAY, MODE_RGB2YCRCB: begin
        d0 = s1_yq_r[23:16];
        d1 = 8'd0;
        d2 = 8'd0;
      end
      MODE_GRAY2RGB: begin
        d0 = s1_a_r;
        d1 = s1_a_r;
        d2 = s1_a_r;
      end
      MODE_YCRCB2RGB: begin
        d0 = sat_q16(40'(s1_y0_r));
        d1 = sat_q16(40'(s1_y1_r));
        d2 = sat_q16(40'(s1_y2_r));
      end
      default: begin
        d0 = 8'd0;
        d1 = 8'd0;
        d2 = 8'd0;
      end
    endcase
    dr = $signed({2'b0, s1_a_r, 16'b0}) - $signed({2'b0, s1_yq_r});
    db = $signed({2'b0, s1_c_r, 16'b0}) - $signed({2'b0, s1_yq_r});
    pcr = dr * KS_CR;
    pcb = db * KS_CB;
  end

  // stage 3
  logic [23:0] cq, mq;
  logic [7:0] e1, e2;
  logic signed [42:0] fcr, fcb;

  logic s3_v_r;
  mode_t s3_mode_r;
  logic [7:0] s3_alpha_r, s3_mx_r, s3_hn_r, s3_hbase_r, s3_d_r, s3_den_r, s3_lum_r;
  logic [7:0] s3_o0_r, s3_o1_r, s3_o2_r;
  logic s3_hneg_r;
  sector_t s3_sec_r;
  logic [4:0] s3_k_r;
  logic [23:0] s3_cq_r, s3_mq_r;

  always_comb begin
    cq = {s2_qa_r, s2_qb_r, s2_qb_r};
    if (s2_mode_r == MODE_HSV2RGB) begin
      mq = {s2_c_r, 16'b0} - cq;
    end else begin
      mq = {s2_b_r, 16'b0} - {1'b0, cq[23:1]};
    end
    fcr = s2_pcr_r >>> 16;
    fcb = s2_pcb_r >>> 16;
    if (s2_mode_r == MODE_RGB2YCRCB) begin
      e1 = sat_q16(40'(fcr) + C_OFFSET_Q16);
      e2 = sat_q16(40'(fcb) + C_OFFSET_Q16);
    end else begin
      e1 = s2_o1_r;
      e2 = s2_o2_r;
    end
  end

  // stage 4: divider setup
  logic [DIV_NW-1:0] xnum, mnum;
  logic [DIV_DW-1:0] mden;
  logic [DIV_QW-1:0] hnum;
  csc_work_t work;

  logic s4_v_r;
  csc_work_t s4_r;

  always_comb begin
    xnum = DIV_NW'(s3_cq_r) * DIV_NW'(s3_k_r);
    if (s3_mode_r == MODE_HSV2RGB || s3_mode_r == MODE_HLS2RGB) begin
      mnum = xnum;
      mden = DIV_DW'(30);
    end else begin
      mnum = DIV_NW'({s3_d_r, 16'b0});
      mden = s3_den_r;
    end
    hnum = DIV_QW'(s3_hn_r) * DIV_QW'(30);
    work.main.rem = DIV_DW'(mnum[DIV_NW-1:DIV_QW]);
    work.main.acc = mnum[DIV_QW-1:0];
    work.main.den = mden;
    work.hue.rem = '0;
    work.hue.acc = hnum;
    work.hue.den = s3_d_r;
    work.side.mode = s3_mode_r;
    work.side.alpha = s3_alpha_r;
    work.side.o0 = s3_o0_r;
    work.side.o1 = s3_o1_r;
    work.side.o2 = s3_o2_r;
    work.side.hbase = s3_hbase_r;
    work.side.hneg = s3_hneg_r;
    work.side.zero = (s3_d_r == 8'd0);
    work.side.mx = s3_mx_r;
    work.side.lum = s3_lum_r;
    work.side.cq = s3_cq_r;
    work.side.mq = s3_mq_r;
    work.side.sec = s3_sec_r;
  end

  assign en4 = !s4_v_r || dn_ready;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign up.ready = en1;
  assign dn_valid = s4_v_r;
  assign dn_data = s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= up.valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
      if (en4) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode_r  <= cfg_mode;
      s1_a_r     <= a;
      s1_b_r     <= b;
      s1_c_r     <= c;
      s1_alpha_r <= up.in_alpha;
      s1_mx_r    <= mx;
      s1_mn_r    <= mn;
      s1_hn_r    <= hn;
      s1_hbase_r <= hbase;
      s1_hneg_r  <= hneg;
      s1_sec_r   <= sec;
      s1_k_r     <= k;
      s1_p_r     <= prod;
      s1_yq_r    <= yq;
      s1_y0_r    <= ybase + p_rcr;
      s1_y1_r    <= ybase - p_gcr - p_gcb;
      s1_y2_r    <= ybase + p_bcb;
    end
    if (en2) begin
      s2_mode_r  <= s1_mode_r;
      s2_b_r     <= s1_b_r;
      s2_c_r     <= s1_c_r;
      s2_alpha_r <= s1_alpha_r;
      s2_mx_r    <= s1_mx_r;
      s2_hn_r    <= s1_hn_r;
      s2_hbase_r <= s1_hbase_r;
      s2_hneg_r  <= s1_hneg_r;
      s2_sec_r   <= s1_sec_r;
      s2_k_r     <= s1_k_r;
      s2_qa_r    <= qa;
      s2_qb_r    <= qb;
      s2_d_r     <= dd;
      s2_den_r   <= den_sat;
      s2_lum_r   <= lum;
      s2_o0_r    <= d0;
      s2_o1_r    <= d1;
      s2_o2_r    <= d2;
      s2_pcr_r   <= pcr;
      s2_pcb_r   <= pcb;
    end
    if (en3) begin
      s3_mode_r  <= s2_mode_r;
      s3_alpha_r <= s2_alpha_r;
      s3_mx_r    <= s2_mx_r;
      s3_hn_r    <= s2_hn_r;
      s3_hbase_r <= s2_hbase_r;
      s3_hneg_r  <= s2_hneg_r;
      s3_sec_r   <= s2_sec_r;
      s3_k_r     <= s2_k_r;
      s3_d_r     <= s2_d_r;
      s3_den_r   <= s2_den_r;
      s3_lum_r   <= s2_lum_r;
      s3_o0_r    <= s2_o0_r;
      s3_o1_r    <= e1;
      s3_o2_r    <= e2;
      s3_cq_r    <= cq;
      s3_mq_r    <= mq;
    end
    if (en4) begin
      s4_r <= work;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes
// (saturation or sector ramp, and hue). Depends on csc_pkg.
`default_nettype none

module csc_div import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  csc_work_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output csc_work_t dn_data
);

  function automatic lane_t div_step(input lane_t l);
    lane_t o;
    logic [DIV_DW:0] t;
    logic bit_q;
    t = {l.rem, l.acc[DIV_QW-1]};
    bit_q = (t >= {1'b0, l.den});
    o.den = l.den;
    o.rem = bit_q ? DIV_DW'(t - {1'b0, l.den}) : t[DIV_DW-1:0];
    o.acc = {l.acc[DIV_QW-2:0], bit_q};
    return o;
  endfunction

  logic      v_r   [DIV_QW];
  csc_work_t d_r   [DIV_QW];
  logic      src_v [DIV_QW];
  csc_work_t src_d [DIV_QW];
  logic      en    [DIV_QW+1];

  assign en[DIV_QW] = dn_ready;
  assign up_ready   = en[0];
  assign dn_valid   = v_r[DIV_QW-1];
  assign dn_data    = d_r[DIV_QW-1];

  for (genvar j = 0; j < DIV_QW; j++) begin : g_stage
    if (j == 0) begin : g_head
      assign src_v[j] = up_valid;
      assign src_d[j] = up_data;
    end else begin : g_body
      assign src_v[j] = v_r[j-1];
      assign src_d[j] = d_r[j-1];
    end
    assign en[j] = !v_r[j] || en[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        d_r[j].main <= div_step(src_d[j].main);
        d_r[j].hue  <= div_step(src_d[j].hue);
        d_r[j].side <= src_d[j].side;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csc_back.sv =====
// Back end: hue, saturation and sector assembly into the output register; other modes pass their results through.
// Depends on csc_pkg and csc_out_if.
`default_nettype none

module csc_back import csc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  csc_work_t up_data,
  csc_out_if.source dn
);

  logic en;
  logic v_r;
  logic [7:0] o0_r, o0_nxt, o1_r, o1_nxt, o2_r, o2_nxt, alpha_r;

  side_t sd;
  logic [4:0] hq;
  logic rem_nz;
  logic [7:0] hue, satv;
  logic [16:0] sq;
  logic [24:0] sprod;
  logic [23:0] xq, pr, pg, pb;

  function automatic logic [7:0] chan_sat(input logic [23:0] p, input logic [23:0] m);
    logic [24:0] s;
    s = {1'b0, p} + {1'b0, m};
    return s[24] ? 8'd255 : s[23:16];
  endfunction

  always_comb begin
    sd = up_data.side;
    hq = up_data.hue.acc[4:0];
    rem_nz = (up_data.hue.rem != '0);
    if (sd.zero) begin
      hue = 8'd0;
    end else if (sd.hneg) begin
      hue = sd.hbase - 8'(hq) - 8'(rem_nz);
    end else begin
      hue = sd.hbase + 8'(hq);
    end
    sq = up_data.main.acc[16:0];
    sprod = {sq, 8'b0} - {8'b0, sq};
    satv = sd.zero ? 8'd0 : sprod[23:16];
    xq = up_data.main.acc;
    pr = '0;
    pg = '0;
    pb = '0;
    unique case (sd.sec)
      SEC_R_Y: begin pr = sd.cq; pg = xq; end
      SEC_Y_G: begin pr = xq; pg = sd.cq; end
      SEC_G_C: begin pg = sd.cq; pb = xq; end
      SEC_C_B: begin pg = xq; pb = sd.cq; end
      SEC_B_M: begin pr = xq; pb = sd.cq; end
      SEC_M_R: begin pr = sd.cq; pb = xq; end
      default: begin end
    endcase
    unique case (sd.mode)
      MODE_RGB2HSV: begin
        o0_nxt = hue;
        o1_nxt = satv;
        o2_nxt = sd.mx;
      end
      MODE_RGB2HLS: begin
        o0_nxt = hue;
        o1_nxt = sd.lum;
        o2_nxt = satv;
      end
      MODE_HSV2RGB, MODE_HLS2RGB: begin
        o0_nxt = chan_sat(pr, sd.mq);
        o1_nxt = chan_sat(pg, sd.mq);
        o2_nxt = chan_sat(pb, sd.mq);
      end
      default: begin
        o0_nxt = sd.o0;
        o1_nxt = sd.o1;
        o2_nxt = sd.o2;
      end
    endcase
  end

  assign en = !v_r || dn.ready;
  assign up_ready = en;
  assign dn.valid = v_r;
  assign dn.out_first = o0_r;
  assign dn.out_second = o1_r;
  assign dn.out_third = o2_r;
  assign dn.out_alpha = alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o0_r    <= o0_nxt;
      o1_r    <= o1_nxt;
      o2_r    <= o2_nxt;
      alpha_r <= sd.alpha;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/color_space_converter_core.sv =====
// An accepted request runs through the front stages, the divider stages and the output register to its result.
// Throughput: one pixel per clock while out_ch is ready; every stage holds its own valid bit.
// The 24-stage divider, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and sets the mode to rgb2gray.
// Depends on csc_pkg, csc_ifs, csc_front, csc_div and csc_back.
`default_nettype none

module color_space_converter_core import csc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  csc_in_if.sink     in_ch,
  csc_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  mode_t mode_r;
  logic fd_valid, fd_ready, db_valid, db_ready;
  csc_work_t fd_data, db_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGB2GRAY;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wr_data);
    end
  end

  csc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_mode (mode_r),
    .up       (in_ch),
    .dn_valid (fd_valid),
    .dn_ready (fd_ready),
    .dn_data  (fd_data)
  );

  csc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fd_valid),
    .up_ready (fd_ready),
    .up_data  (fd_data),
    .dn_valid (db_valid),
    .dn_ready (db_ready),
    .dn_data  (db_data)
  );

  csc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (db_valid),
    .up_ready (db_ready),
    .up_data  (db_data),
    .dn       (out_ch)
  );

  a_gray_planes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && mode_r == MODE_RGB2GRAY) |->
      (out_ch.out_second == 8'd0 && out_ch.out_third == 8'd0))
    else $error("gray result with nonzero chroma planes");

  a_gray_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && mode_r == MODE_GRAY2RGB) |->
      (out_ch.out_first == out_ch.out_second && out_ch.out_second == out_ch.out_third))
    else $error("gray expansion channels differ");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (mode_r == MODE_RGB2HSV || mode_r == MODE_RGB2HLS)) |->
      (out_ch.out_first < 8'd180))
    else $error("hue out of range");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
